// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL that carries checks.
// Each macro expects a clock named clk and an active-low reset named arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== rtl/ipbs_pkg.sv =====
// Shared types, register codes and width helpers for the integer power unit.
// No dependencies; every other RTL file imports this package.
package ipbs_pkg;

	localparam int unsigned MAX_BITS_DEFAULT = 64;

	// Configuration port geometry: two 32-bit registers at byte addresses 0 and 4.
	localparam int unsigned ADDR_W = 3;
	localparam int unsigned DATA_W = 32;

	localparam logic REG_SIGNED_MODE  = 1'b0;
	localparam logic REG_WIDTH_SELECT = 1'b1;

	localparam logic       SIGNED_MODE_RESET  = 1'b1;
	localparam logic [1:0] WIDTH_SELECT_RESET = 2'd3;

	typedef struct packed {
		logic       signed_mode;
		logic [1:0] width_select;
	} cfg_t;

	// Element width in bits, clamped to the datapath width.
	function automatic logic [6:0] elem_width(logic [1:0] ws, int unsigned maxb);
		logic [6:0] w;
		w = 7'd8 << ws;
		if (w > 7'(maxb)) begin
			w = 7'(maxb);
		end
		return w;
	endfunction

	// Low-order mask of wsz ones; wsz is between 8 and 64.
	function automatic logic [63:0] width_mask64(logic [6:0] wsz);
		return ~64'd0 >> (7'd64 - wsz);
	endfunction

endpackage

// ===== rtl/ipbs_cfg_regs.sv =====
// Configuration register file behind the APB-style port.
// Depends on ipbs_pkg for register codes, reset values and cfg_t.
module ipbs_cfg_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [ipbs_pkg::ADDR_W-1:0]  paddr,
	input  logic [ipbs_pkg::DATA_W-1:0]  pwdata,
	output logic [ipbs_pkg::DATA_W-1:0]  prdata,
	output logic                         pready,
	output ipbs_pkg::cfg_t               cfg
);
	import ipbs_pkg::*;

	logic       signed_mode_q;
	logic [1:0] width_select_q;
	logic       wr_en;
	logic       reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite && pready;
	assign reg_idx = paddr[ADDR_W-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			signed_mode_q  <= SIGNED_MODE_RESET;
			width_select_q <= WIDTH_SELECT_RESET;
		end else if (wr_en) begin
			case (reg_idx)
				REG_SIGNED_MODE:  signed_mode_q  <= pwdata[0];
				REG_WIDTH_SELECT: width_select_q <= pwdata[1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_SIGNED_MODE:  prdata = {{(DATA_W-1){1'b0}}, signed_mode_q};
			REG_WIDTH_SELECT: prdata = {{(DATA_W-2){1'b0}}, width_select_q};
			default:          prdata = '0;
		endcase
	end

	assign cfg.signed_mode  = signed_mode_q;
	assign cfg.width_select = width_select_q;

endmodule

// ===== rtl/ipbs_mul_lo.sv =====
// Two-stage multiplier that keeps the low DW bits of a DW x DW product.
// Splits the operands into halves; depends on ipbs_pkg only for the default of DW.
module ipbs_mul_lo #(
	parameter int unsigned DW = ipbs_pkg::MAX_BITS_DEFAULT
) (
	input  logic          clk,
	input  logic [DW-1:0] a,
	input  logic [DW-1:0] b,
	output logic [DW-1:0] p
);
	import ipbs_pkg::*;

	localparam int unsigned LO = (DW + 1) / 2;
	localparam int unsigned HI = DW - LO;

	logic [2*LO-1:0] pll_s1;
	logic [HI-1:0]   c1_s1;
	logic [HI-1:0]   c2_s1;
	logic [DW-1:0]   p_s2;

	// Cross terms only reach the upper HI bits, so keep their low HI bits.
	always_ff @(posedge clk) begin
		pll_s1 <= (2*LO)'(a[LO-1:0]) * (2*LO)'(b[LO-1:0]);
		c1_s1  <= a[HI-1:0] * b[DW-1:LO];
		c2_s1  <= a[DW-1:LO] * b[HI-1:0];
		p_s2   <= pll_s1[DW-1:0] + {HI'(c1_s1 + c2_s1), LO'(1'b0)};
	end

	assign p = p_s2;

endmodule

// ===== rtl/ipbs_prep.sv =====
// Entry stage: masks operands to the element width and folds the
// negative-exponent cases into an equivalent base^1. Depends on ipbs_pkg.
module ipbs_prep #(
	parameter int unsigned DW = ipbs_pkg::MAX_BITS_DEFAULT
) (
	input  logic           clk,
	input  logic           arst_n,
	input  ipbs_pkg::cfg_t cfg,
	input  logic           vld_in,
	input  logic [DW-1:0]  base_in,
	input  logic [DW-1:0]  exp_in,
	output logic           vld_out,
	output logic [DW-1:0]  b_out,
	output logic [DW-1:0]  e_out
);
	import ipbs_pkg::*;

	logic [DW-1:0] m;
	logic [DW-1:0] top_bit;
	logic [DW-1:0] b_m;
	logic [DW-1:0] e_m;
	logic          neg;
	logic [DW-1:0] b_sel;
	logic [DW-1:0] e_sel;
	logic          vld_s1;
	logic [DW-1:0] b_s1;
	logic [DW-1:0] e_s1;

	assign m       = DW'(width_mask64(elem_width(cfg.width_select, DW)));
	assign top_bit = m ^ (m >> 1);
	assign b_m     = base_in & m;
	assign e_m     = exp_in & m;
	assign neg     = cfg.signed_mode && ((e_m & top_bit) != '0);

	// Negative exponent: raise the special result to the first power.
	always_comb begin
		b_sel = b_m;
		e_sel = e_m;
		if (neg) begin
			e_sel = DW'(1);
			if (b_m == DW'(1)) begin
				b_sel = DW'(1);
			end else if (b_m == m) begin
				b_sel = e_m[0] ? m : DW'(1);
			end else begin
				b_sel = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		b_s1 <= b_sel;
		e_s1 <= e_sel;
	end

	assign vld_out = vld_s1;
	assign b_out   = b_s1;
	assign e_out   = e_s1;

endmodule

// ===== rtl/ipbs_step.sv =====
// One square-and-multiply round over two pipeline stages.
// Uses ipbs_mul_lo for the conditional multiply and the squaring.
module ipbs_step #(
	parameter int unsigned DW = ipbs_pkg::MAX_BITS_DEFAULT
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          vld_in,
	input  logic [DW-1:0] r_in,
	input  logic [DW-1:0] b_in,
	input  logic [DW-1:0] e_in,
	output logic          vld_out,
	output logic [DW-1:0] r_out,
	output logic [DW-1:0] b_out,
	output logic [DW-1:0] e_out
);
	import ipbs_pkg::*;

	logic [DW-1:0] mul_sel;
	logic          vld_s1;
	logic          vld_s2;
	logic [DW-1:0] e_s1;
	logic [DW-1:0] e_s2;

	// Multiply by one when the current exponent bit is clear.
	assign mul_sel = e_in[0] ? b_in : DW'(1);

	ipbs_mul_lo #(.DW(DW)) u_mul_r (
		.clk (clk),
		.a   (r_in),
		.b   (mul_sel),
		.p   (r_out)
	);

	ipbs_mul_lo #(.DW(DW)) u_mul_b (
		.clk (clk),
		.a   (b_in),
		.b   (b_in),
		.p   (b_out)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= vld_in;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		e_s1 <= e_in >> 1;
		e_s2 <= e_s1;
	end

	assign vld_out = vld_s2;
	assign e_out   = e_s2;

endmodule

// ===== rtl/integer_power_by_squaring_unit.sv =====
// Top level of the integer power unit: config registers, entry stage,
// MAX_BITS square-and-multiply rounds and the output register. Depends on ipbs_pkg.
//
//  channel   handshake           payload                       direction
//  config    psel/penable/pready paddr, pwdata, prdata         in/out
//  command   start / busy        base_bits, exponent_bits      in
//  result    done (strobe)       power_bits                    out
//
// One command per cycle; busy stays low. The path runs through an entry stage,
// two stages per exponent bit (partial products, then the sum of the split
// multiplier), and the output register.
// Reset clears the valid bits and loads the register defaults; no clearing pass.
// The pipeline never stalls; done pulses for one cycle per result.
module integer_power_by_squaring_unit #(
	parameter int unsigned MAX_BITS = ipbs_pkg::MAX_BITS_DEFAULT
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [ipbs_pkg::ADDR_W-1:0]  paddr,
	input  logic [ipbs_pkg::DATA_W-1:0]  pwdata,
	output logic [ipbs_pkg::DATA_W-1:0]  prdata,
	output logic                         pready,
	input  logic                         start,
	output logic                         busy,
	input  logic [63:0]                  base_bits,
	input  logic [63:0]                  exponent_bits,
	output logic                         done,
	output logic [63:0]                  power_bits
);
	import ipbs_pkg::*;

	localparam int unsigned LAT = 2 * MAX_BITS + 2;

	cfg_t                cfg;
	logic                accept;
	logic                vld_c [0:MAX_BITS];
	logic [MAX_BITS-1:0] r_c   [0:MAX_BITS];
	logic [MAX_BITS-1:0] b_c   [0:MAX_BITS];
	logic [MAX_BITS-1:0] e_c   [0:MAX_BITS];
	logic [MAX_BITS-1:0] out_mask;
	logic                done_q;
	logic [MAX_BITS-1:0] power_bits_q;

	ipbs_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign busy   = 1'b0;
	assign accept = start && !busy;

	ipbs_prep #(.DW(MAX_BITS)) u_prep (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.vld_in  (accept),
		.base_in (base_bits[MAX_BITS-1:0]),
		.exp_in  (exponent_bits[MAX_BITS-1:0]),
		.vld_out (vld_c[0]),
		.b_out   (b_c[0]),
		.e_out   (e_c[0])
	);

	assign r_c[0] = MAX_BITS'(1);

	for (genvar g = 0; g < MAX_BITS; g++) begin : g_round
		ipbs_step #(.DW(MAX_BITS)) u_step (
			.clk     (clk),
			.arst_n  (arst_n),
			.vld_in  (vld_c[g]),
			.r_in    (r_c[g]),
			.b_in    (b_c[g]),
			.e_in    (e_c[g]),
			.vld_out (vld_c[g+1]),
			.r_out   (r_c[g+1]),
			.b_out   (b_c[g+1]),
			.e_out   (e_c[g+1])
		);
	end

	// The user keeps the registers stable while results are in flight; not enforced.
	assign out_mask = MAX_BITS'(width_mask64(elem_width(cfg.width_select, MAX_BITS)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= vld_c[MAX_BITS];
		end
	end

	always_ff @(posedge clk) begin
		power_bits_q <= r_c[MAX_BITS] & out_mask;
	end

	assign done       = done_q;
	assign power_bits = 64'(power_bits_q);

	`include "assert_macros.svh"

	// Every result strobe traces back to an accepted transaction.
	`ASSERT_IMPLIES(a_done_has_cmd, done, $past(accept, LAT))
	// Bits above the element width are zero on every result.
	`ASSERT_IMPLIES(a_upper_zero, done,
		(power_bits & ~width_mask64(elem_width(cfg.width_select, MAX_BITS))) == 64'd0)
	// An accepted transaction reaches the first round's input next cycle.
	`ASSERT_NEXT(a_entry_valid, accept, vld_c[0])

endmodule
